FILE: rtl/core/kvt_pkg.sv
// shared constants, types and helpers for the key/value table
`default_nettype none
package kvt_pkg;

	localparam int ENTRIES   = 64;
	localparam int KEY_BYTES = 16;
	localparam int WORD_W    = 64;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_NOOP = 2'd0,
		OP_SET  = 2'd1,
		OP_GET  = 2'd2,
		OP_DEL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// mask of the top n bytes of a 64-bit word, n clamped to 0..8
	function automatic logic [WORD_W-1:0] top_bytes_mask(input int n);
		logic [WORD_W-1:0] m;
		if (n <= 0) begin
			m = '0;
		end else if (n >= 8) begin
			m = '1;
		end else begin
			m = {WORD_W{1'b1}} << (WORD_W - 8 * n);
		end
		return m;
	endfunction

	localparam logic [WORD_W-1:0] KEY_MASK_HI = top_bytes_mask(KEY_BYTES);
	localparam logic [WORD_W-1:0] KEY_MASK_LO = top_bytes_mask(KEY_BYTES - 8);

endpackage
`default_nettype wire

FILE: rtl/core/key_value_table.sv
// key/value table: linear search of up to ENTRIES keys with one comparator.
// a no-op goes straight to the answer; a set or get scans slot by slot until a hit or
// until it is past the last entry, and a delete hit then moves the last entry into the
// freed slot (read, then write) before the answer.
// one item at a time: the next item is taken once the answer is offered.
// reset clears the entry count and the handshakes; the rams are not cleared.
`default_nettype none
module key_value_table (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,  // key_high, key_low, new_value
	input  wire logic [1:0]   s_axis_tuser,  // func
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [63:0]  m_axis_tdata,  // read_value
	output logic      [1:0]   m_axis_tuser   // status
);
	import kvt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [WORD_W-1:0] key_hi_q, key_lo_q, val_q;
	logic [CNT_W-1:0]  cnt_q, idx_q;
	logic              pend_q;
	logic [IDX_W-1:0]  pend_idx_q, at_q;
	status_t           res_status_q;
	logic [WORD_W-1:0] res_value_q;

	logic [IDX_W-1:0]  raddr, waddr;
	logic              key_we, val_we;
	logic [WORD_W-1:0] wkey_hi, wkey_lo, wval;
	logic [WORD_W-1:0] rkey_hi, rkey_lo, rval;
	logic              match, hit, accept;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	kvt_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_key_hi (
		.clk(clk), .we(key_we), .waddr(waddr), .wdata(wkey_hi),
		.raddr(raddr), .rdata(rkey_hi)
	);
	kvt_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_key_lo (
		.clk(clk), .we(key_we), .waddr(waddr), .wdata(wkey_lo),
		.raddr(raddr), .rdata(rkey_lo)
	);
	kvt_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_value (
		.clk(clk), .we(val_we), .waddr(waddr), .wdata(wval),
		.raddr(raddr), .rdata(rval)
	);

	kvt_match u_match (
		.stored_hi(rkey_hi), .stored_lo(rkey_lo),
		.req_hi(key_hi_q), .req_lo(key_lo_q),
		.hit(match)
	);

	assign hit = (state_q == S_SCAN) && pend_q && match;

	// read port: scan index, or the last entry during a delete move
	always_comb begin
		if (state_q == S_MOVE_RD) begin
			raddr = cnt_q[IDX_W-1:0];
		end else begin
			raddr = idx_q[IDX_W-1:0];
		end
	end

	// write port: value overwrite on a set hit, append on a set miss, move on delete
	always_comb begin
		key_we  = 1'b0;
		val_we  = 1'b0;
		waddr   = pend_idx_q;
		wkey_hi = key_hi_q;
		wkey_lo = key_lo_q;
		wval    = val_q;
		unique case (state_q)
			S_SCAN: begin
				if (hit) begin
					val_we = (op_q == OP_SET);
				end else if (op_q == OP_SET && !pend_q && idx_q >= cnt_q &&
				             cnt_q < CNT_W'(ENTRIES)) begin
					key_we = 1'b1;
					val_we = 1'b1;
					waddr  = cnt_q[IDX_W-1:0];
				end
			end
			S_MOVE_WR: begin
				key_we  = 1'b1;
				val_we  = 1'b1;
				waddr   = at_q;
				wkey_hi = rkey_hi;
				wkey_lo = rkey_lo;
				wval    = rval;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			idx_q         <= '0;
			pend_q        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			// the done state loads the next answer itself
			if (m_axis_tvalid && m_axis_tready && state_q != S_DONE) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= op_t'(s_axis_tuser);
						key_hi_q     <= s_axis_tdata[63:0];
						key_lo_q     <= s_axis_tdata[127:64];
						val_q        <= s_axis_tdata[191:128];
						idx_q        <= '0;
						pend_q       <= 1'b0;
						res_status_q <= ST_OK;
						res_value_q  <= '0;
						if (op_t'(s_axis_tuser) == OP_NOOP) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						pend_q <= 1'b0;
						if (op_q == OP_SET) begin
							state_q <= S_DONE;
						end else if (op_q == OP_GET) begin
							res_value_q <= rval;
							state_q     <= S_DONE;
						end else begin
							res_value_q <= rval;
							at_q        <= pend_idx_q;
							cnt_q       <= cnt_q - 1'b1;
							state_q     <= S_MOVE_RD;
						end
					end else if (idx_q < cnt_q) begin
						pend_q     <= 1'b1;
						pend_idx_q <= idx_q[IDX_W-1:0];
						idx_q      <= idx_q + 1'b1;
					end else if (pend_q) begin
						// last read in flight missed; settle next cycle
						pend_q <= 1'b0;
					end else begin
						state_q <= S_DONE;
						if (op_q == OP_SET) begin
							if (cnt_q < CNT_W'(ENTRIES)) begin
								cnt_q <= cnt_q + 1'b1;
							end else begin
								res_status_q <= ST_FULL;
							end
						end else begin
							res_status_q <= ST_MISSING;
						end
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser  <= res_status_q;
						m_axis_tdata  <= res_value_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/kvt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module kvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/kvt_match.sv
// masked key compare shared by every step of the search
`default_nettype none
module kvt_match (
	input  wire logic [kvt_pkg::WORD_W-1:0] stored_hi,
	input  wire logic [kvt_pkg::WORD_W-1:0] stored_lo,
	input  wire logic [kvt_pkg::WORD_W-1:0] req_hi,
	input  wire logic [kvt_pkg::WORD_W-1:0] req_lo,
	output logic                            hit
);
	import kvt_pkg::*;

	// bytes past the key length are stored but ignored
	assign hit = (((stored_hi ^ req_hi) & KEY_MASK_HI) == '0) &&
	             (((stored_lo ^ req_lo) & KEY_MASK_LO) == '0);

endmodule
`default_nettype wire

FILE: test/key_value_table_checker.sv
// checker for the key/value table: watches both channels, predicts each answer and compares
`timescale 1ns / 1ps
module key_value_table_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,  // key_high, key_low, new_value
	input  wire logic [1:0]   s_axis_tuser,  // func
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [63:0]  m_axis_tdata,  // read_value
	input  wire logic [1:0]   m_axis_tuser,  // status
	output int                error_count,
	output int                pending
);
	import kvt_pkg::*;

	typedef struct {
		status_t           status;
		logic [WORD_W-1:0] read_value;
	} answer_t;

	logic [WORD_W-1:0] stored_key_hi [ENTRIES];
	logic [WORD_W-1:0] stored_key_lo [ENTRIES];
	logic [WORD_W-1:0] stored_value  [ENTRIES];
	int                live_count = 0;
	answer_t           answers_due[$];
	answer_t           oldest;
	int                fail_tally = 0;
	int                due_count = 0;

	assign error_count = fail_tally;
	assign pending     = due_count;

	task automatic report_mismatch(input string what);
		// keep the log short when the block is badly broken
		if (fail_tally < 100) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
		fail_tally++;
	endtask

	function automatic int find_key(input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo);
		for (int i = 0; i < live_count; i++) begin
			if (((stored_key_hi[i] ^ hi) & KEY_MASK_HI) == '0 &&
			    ((stored_key_lo[i] ^ lo) & KEY_MASK_LO) == '0) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic answer_t predict_answer(input op_t func, input logic [WORD_W-1:0] kh,
			input logic [WORD_W-1:0] kl, input logic [WORD_W-1:0] nv);
		answer_t ans;
		int      slot;
		ans.status     = ST_OK;
		ans.read_value = '0;
		slot = find_key(kh, kl);
		case (func)
			OP_SET: begin
				if (slot < 0) begin
					if (live_count >= ENTRIES) begin
						ans.status = ST_FULL;
					end else begin
						slot = live_count;
						live_count++;
						stored_key_hi[slot] = kh;
						stored_key_lo[slot] = kl;
					end
				end
				if (slot >= 0) begin
					stored_value[slot] = nv;
				end
			end
			OP_GET: begin
				if (slot < 0) begin
					ans.status = ST_MISSING;
				end else begin
					ans.read_value = stored_value[slot];
				end
			end
			OP_DEL: begin
				if (slot < 0) begin
					ans.status = ST_MISSING;
				end else begin
					ans.read_value = stored_value[slot];
					live_count--;
					// last entry fills the hole
					stored_key_hi[slot] = stored_key_hi[live_count];
					stored_key_lo[slot] = stored_key_lo[live_count];
					stored_value[slot]  = stored_value[live_count];
				end
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_count = 0;
			answers_due.delete();
			due_count <= 0;
		end else begin
			// an answer always trails its request
			if (m_axis_tvalid && m_axis_tready) begin
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("answer with none due: status %0d value %h",
						m_axis_tuser, m_axis_tdata));
				end else begin
					oldest = answers_due.pop_front();
					if (m_axis_tuser !== oldest.status || m_axis_tdata !== oldest.read_value) begin
						report_mismatch($sformatf("status %0d value %h, expected status %0d value %h",
							m_axis_tuser, m_axis_tdata, oldest.status, oldest.read_value));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				answers_due.push_back(predict_answer(op_t'(s_axis_tuser), s_axis_tdata[63:0],
					s_axis_tdata[127:64], s_axis_tdata[191:128]));
			end
			due_count <= answers_due.size();
		end
	end

endmodule

FILE: test/testbench.sv
// top of the key/value table testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module testbench;
	import kvt_pkg::*;

	localparam int KEY_POOL = 80;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata = '0;  // key_high, key_low, new_value
	logic [1:0]   s_axis_tuser = '0;  // func
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;       // read_value
	logic [1:0]   m_axis_tuser;       // status
	int           error_count;
	int           pending;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	logic [63:0]  pool_hi [KEY_POOL];
	logic [63:0]  pool_lo [KEY_POOL];

	key_value_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	key_value_table_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.error_count   (error_count),
		.pending       (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// called at a clock edge; returns at the edge where the item is taken
	task automatic send_request(input op_t func, input logic [63:0] kh, input logic [63:0] kl,
			input logic [63:0] nv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {nv, kl, kh};
		s_axis_tuser  <= func;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	task automatic wait_for_answers();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_random_request();
		int          pick;
		int          idx;
		op_t         func;
		logic [63:0] kh;
		logic [63:0] kl;
		logic [63:0] nv;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			func = OP_NOOP;
		end else if (pick < 40) begin
			func = OP_SET;
		end else if (pick < 70) begin
			func = OP_GET;
		end else begin
			func = OP_DEL;
		end
		if ($urandom_range(0, 99) < 85) begin
			idx = $urandom_range(0, KEY_POOL - 1);
			kh  = pool_hi[idx];
			kl  = pool_lo[idx];
		end else begin
			kh = rand_word();
			kl = rand_word();
		end
		case ($urandom_range(0, 9))
			0:       nv = '0;
			1:       nv = '1;
			default: nv = rand_word();
		endcase
		send_request(func, kh, kl, nv);
	endtask

	initial begin
		int          bit_pos;
		logic [63:0] ones;
		ones = '1;
		// every fourth pool key differs from the previous pool key in a single bit
		for (int i = 0; i < KEY_POOL; i++) begin
			if (i % 4 == 3) begin
				bit_pos    = $urandom_range(0, 127);
				pool_hi[i] = pool_hi[i-1];
				pool_lo[i] = pool_lo[i-1];
				if (bit_pos < 64) begin
					pool_hi[i][bit_pos] = ~pool_hi[i][bit_pos];
				end else begin
					pool_lo[i][bit_pos-64] = ~pool_lo[i][bit_pos-64];
				end
			end else begin
				pool_hi[i] = rand_word();
				pool_lo[i] = rand_word();
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 50;

		// directed: empty table, extremes, overwrite, near-miss keys, delete with move
		send_request(OP_NOOP, ones, ones, ones);
		send_request(OP_GET, '0, '0, ones);
		send_request(OP_DEL, '0, '0, ones);
		send_request(OP_SET, '0, '0, ones);
		send_request(OP_SET, ones, ones, '0);
		send_request(OP_GET, '0, '0, '0);
		send_request(OP_GET, ones, ones, ones);
		send_request(OP_SET, '0, '0, 64'h5555_aaaa_0f0f_f0f0);
		send_request(OP_GET, '0, '0, '0);
		send_request(OP_GET, '0, 64'h1, '0);
		send_request(OP_GET, 64'h8000_0000_0000_0000, '0, '0);
		send_request(OP_SET, ones, 64'hffff_ffff_ffff_fffe, 64'h1234_5678_9abc_def0);
		send_request(OP_DEL, '0, '0, '0);
		send_request(OP_GET, ones, ones, '0);
		send_request(OP_GET, ones, 64'hffff_ffff_ffff_fffe, '0);
		send_request(OP_DEL, ones, ones, '0);
		send_request(OP_DEL, ones, ones, '0);
		send_request(OP_DEL, ones, 64'hffff_ffff_ffff_fffe, ones);
		send_request(OP_GET, ones, 64'hffff_ffff_ffff_fffe, '0);
		send_request(OP_NOOP, '0, '0, '0);
		wait_for_answers();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// fill past capacity so new keys get the full answer
			for (int i = 0; i < 70; i++) begin
				send_request(OP_SET, pool_hi[i], pool_lo[i], rand_word());
			end
			for (int i = 0; i < 110; i++) begin
				send_random_request();
			end
			wait_for_answers();
		end

		repeat (2 * ENTRIES + 10) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
